FILE: rtl/rssi_pkg.sv
package rssi_pkg;

  // Field and bus widths
  localparam int FLD_W       = 32;
  localparam int RSQ_W       = 31;
  localparam int CRD_W_DEF   = 32;
  localparam int IN_TDATA_W  = 320;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;

  // Arithmetic widths
  localparam int SQ_XW  = 64;  // radicand width of both square roots
  localparam int LEN_W  = 32;  // segment length, Q16.16 unsigned
  localparam int QUO_W  = 17;  // |dir| magnitude, at most 1.0 in Q16.16
  localparam int DIR_W  = 18;  // signed direction component
  localparam int C_W    = 49;  // c = m.m - r^2
  localparam int NUM_W  = LEN_W + QUO_W - 1;

  // Output flag positions in tuser
  localparam int USR_HIT = 0;
  localparam int USR_DEG = 1;

  // Payload carried alongside the length square root
  typedef struct packed {
    logic [2:0][FLD_W-1:0] st;
    logic [2:0][FLD_W-1:0] sg;
    logic [2:0][FLD_W-1:0] m;
    logic signed [C_W-1:0] c;
  } sq1_pl_t;

  // Payload carried alongside the divider
  typedef struct packed {
    logic [2:0][FLD_W-1:0] st;
    logic [2:0]            sgn;
    logic [2:0][FLD_W-1:0] m;
    logic signed [C_W-1:0] c;
    logic [LEN_W-1:0]      len;
  } div_pl_t;

  // Payload carried alongside the discriminant square root
  typedef struct packed {
    logic [FLD_W-1:0]      b;
    logic [2:0][FLD_W-1:0] st;
    logic [2:0][DIR_W-1:0] dir;
    logic [LEN_W-1:0]      len;
    logic                  miss;
    logic                  deg;
  } sq2_pl_t;

endpackage

FILE: rtl/rssi_isqrt.sv
module rssi_isqrt #(
  parameter int XW = 64,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            ce,
  input  logic            in_valid,
  input  logic [XW-1:0]   in_x,
  input  logic [PW-1:0]   in_pl,
  output logic            out_valid,
  output logic [XW/2-1:0] out_root,
  output logic [PW-1:0]   out_pl
);

  localparam int RTW  = XW / 2;
  localparam int REMW = RTW + 3;
  localparam int NS   = RTW;

  logic [XW-1:0]   x_r    [NS];
  logic [REMW-1:0] rem_r  [NS];
  logic [RTW-1:0]  root_r [NS];
  logic [PW-1:0]   pl_r   [NS];
  logic            v_r    [NS];

  // One root bit per stage, two radicand bits shifted in each time
  for (genvar k = 0; k < NS; k++) begin : g_st
    logic [XW-1:0]   px;
    logic [REMW-1:0] prm;
    logic [RTW-1:0]  prt;
    logic [PW-1:0]   ppl;
    logic            pv;
    logic [REMW-1:0] rsh;
    logic [REMW-1:0] trl;

    if (k == 0) begin : g_in
      assign px  = in_x;
      assign prm = '0;
      assign prt = '0;
      assign ppl = in_pl;
      assign pv  = in_valid;
    end else begin : g_mid
      assign px  = x_r[k-1];
      assign prm = rem_r[k-1];
      assign prt = root_r[k-1];
      assign ppl = pl_r[k-1];
      assign pv  = v_r[k-1];
    end

    assign rsh = {prm[REMW-3:0], px[XW-1 -: 2]};
    assign trl = {1'b0, prt, 2'b01};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        x_r[k]  <= px << 2;
        pl_r[k] <= ppl;
        if (rsh >= trl) begin
          rem_r[k]  <= rsh - trl;
          root_r[k] <= {prt[RTW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rsh;
          root_r[k] <= {prt[RTW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_pl    = pl_r[NS-1];

endmodule

FILE: rtl/rssi_div.sv
module rssi_div #(
  parameter int DW = 32,
  parameter int QW = 17,
  parameter int LN = 3,
  parameter int PW = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ce,
  input  logic                       in_valid,
  input  logic [LN-1:0][DW+QW-2:0]   in_num,
  input  logic [DW-1:0]              in_den,
  input  logic [PW-1:0]              in_pl,
  output logic                       out_valid,
  output logic [LN-1:0][QW-1:0]      out_quo,
  output logic [PW-1:0]              out_pl
);

  localparam int NW = DW + QW - 1;

  logic [NW-1:0] rem_r [QW][LN];
  logic [QW-1:0] quo_r [QW][LN];
  logic [DW-1:0] den_r [QW];
  logic [PW-1:0] pl_r  [QW];
  logic          v_r   [QW];

  // Restoring division, one quotient bit per stage, all lanes share the divisor
  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [NW-1:0] prem [LN];
    logic [QW-1:0] pquo [LN];
    logic [DW-1:0] pden;
    logic [PW-1:0] ppl;
    logic          pv;
    logic [NW-1:0] dsh;

    if (k == 0) begin : g_in
      for (genvar l = 0; l < LN; l++) begin : g_ln
        assign prem[l] = in_num[l];
        assign pquo[l] = '0;
      end
      assign pden = in_den;
      assign ppl  = in_pl;
      assign pv   = in_valid;
    end else begin : g_mid
      for (genvar l = 0; l < LN; l++) begin : g_ln
        assign prem[l] = rem_r[k-1][l];
        assign pquo[l] = quo_r[k-1][l];
      end
      assign pden = den_r[k-1];
      assign ppl  = pl_r[k-1];
      assign pv   = v_r[k-1];
    end

    assign dsh = NW'(pden) << (QW - 1 - k);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        den_r[k] <= pden;
        pl_r[k]  <= ppl;
        for (int l = 0; l < LN; l++) begin
          if (prem[l] >= dsh) begin
            rem_r[k][l] <= prem[l] - dsh;
            quo_r[k][l] <= {pquo[l][QW-2:0], 1'b1};
          end else begin
            rem_r[k][l] <= prem[l];
            quo_r[k][l] <= {pquo[l][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  for (genvar l = 0; l < LN; l++) begin : g_out
    assign out_quo[l] = quo_r[QW-1][l];
  end
  assign out_valid = v_r[QW-1];
  assign out_pl    = pl_r[QW-1];

endmodule

FILE: rtl/ray_segment_sphere_intersect_top.sv
// Segment against sphere intersection, signed Q16.16, fully pipelined.
// Pipeline: two 32-stage square roots, a 17-stage divider and 11 arithmetic/output
// registers between the input transfer and out_tvalid.
// Throughput: one item per cycle unless the output stalls; bubbles collapse while the output is stalled.
// Reset: synchronous active-low rst_n clears all valid bits; data regs are not reset.
module ray_segment_sphere_intersect_top #(
  parameter int COORD_WIDTH = rssi_pkg::CRD_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // start_x, start_y, start_z, seg_x, seg_y, seg_z, centre_x, centre_y,
  // centre_z (32 bits each), radius_sq (31 bits), one zero pad bit
  input  logic [rssi_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // point_x, point_y, point_z (32 bits each)
  output logic [rssi_pkg::OUT_TDATA_W-1:0] out_tdata,
  // hit, degenerate
  output logic [rssi_pkg::OUT_TUSER_W-1:0] out_tuser
);

  import rssi_pkg::*;

  localparam int CW = (COORD_WIDTH > FLD_W) ? FLD_W :
                      ((COORD_WIDTH < 16) ? 16 : COORD_WIDTH);
  localparam int SXS = FLD_W - CW;
  localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CW - 1)) - 64'sd1;
  localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

  // Sign-extend the low CW bits of a field
  function automatic logic signed [FLD_W-1:0] sx(input logic [FLD_W-1:0] v);
    logic signed [FLD_W-1:0] sh;
    sh = $signed(v << SXS);
    return sh >>> SXS;
  endfunction

  // Saturate to a CW-bit signed value
  function automatic logic signed [FLD_W-1:0] sat(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI;
    end else if (v < SAT_LO) begin
      r = SAT_LO;
    end else begin
      r = v;
    end
    return r[FLD_W-1:0];
  endfunction

  function automatic logic [FLD_W-1:0] abs32(input logic signed [FLD_W-1:0] v);
    return (v < 0) ? FLD_W'(-v) : FLD_W'(v);
  endfunction

  // Pipeline advance: output slot free, or the last stage holds a bubble
  logic out_can;
  logic ce;
  logic v_k_r;

  assign out_can   = !out_tvalid || out_tready;
  assign ce        = out_can || !v_k_r;
  assign in_tready = ce;

  // ---------------- Stage A: sign extend, m = start - centre
  logic                  v_a_r;
  logic [2:0][FLD_W-1:0] st_a_r, sg_a_r, m_a_r;
  logic [RSQ_W-1:0]      r2_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (ce) begin
      v_a_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        st_a_r[i] <= sx(in_tdata[FLD_W*i +: FLD_W]);
        sg_a_r[i] <= sx(in_tdata[FLD_W*(3+i) +: FLD_W]);
        m_a_r[i]  <= sat(64'(sx(in_tdata[FLD_W*i +: FLD_W])) -
                         64'(sx(in_tdata[FLD_W*(6+i) +: FLD_W])));
      end
      r2_a_r <= in_tdata[FLD_W*9 +: RSQ_W];
    end
  end

  // ---------------- Stage B: squares
  logic                  v_b_r;
  logic [2:0][FLD_W-1:0] st_b_r, sg_b_r, m_b_r;
  logic [2:0][62:0]      gq_b_r, mq_b_r;
  logic [RSQ_W-1:0]      r2_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (ce) begin
      v_b_r <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] ga, ma;
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        ga = 64'(abs32(sg_a_r[i]));
        ma = 64'(abs32(m_a_r[i]));
        gq_b_r[i] <= 63'(ga * ga);
        mq_b_r[i] <= 63'(ma * ma);
      end
      st_b_r <= st_a_r;
      sg_b_r <= sg_a_r;
      m_b_r  <= m_a_r;
      r2_b_r <= r2_a_r;
    end
  end

  // ---------------- Stage C: sum of squares, c
  logic        v_c_r;
  logic [63:0] ssq_c_r;
  sq1_pl_t     pl_c_r;
  logic [63:0] mm_nxt;

  assign mm_nxt = 64'(mq_b_r[0]) + 64'(mq_b_r[1]) + 64'(mq_b_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (ce) begin
      v_c_r <= v_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ssq_c_r   <= 64'(gq_b_r[0]) + 64'(gq_b_r[1]) + 64'(gq_b_r[2]);
      pl_c_r.st <= st_b_r;
      pl_c_r.sg <= sg_b_r;
      pl_c_r.m  <= m_b_r;
      pl_c_r.c  <= $signed({1'b0, mm_nxt[63:16]}) - $signed(C_W'(r2_b_r));
    end
  end

  // ---------------- Segment length
  logic             v_l;
  logic [LEN_W-1:0] len_l;
  sq1_pl_t          pl_l;

  rssi_isqrt #(.XW(SQ_XW), .PW($bits(sq1_pl_t))) u_sqrt_len (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .in_valid(v_c_r), .in_x(ssq_c_r), .in_pl(pl_c_r),
    .out_valid(v_l), .out_root(len_l), .out_pl(pl_l)
  );

  // ---------------- Direction: |seg| * 2^16 / len
  logic [2:0][NUM_W-1:0] num_l;
  div_pl_t               dpl_l;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_l[i]     = {abs32(pl_l.sg[i]), 16'b0};
      dpl_l.sgn[i] = pl_l.sg[i][FLD_W-1];
    end
    dpl_l.st  = pl_l.st;
    dpl_l.m   = pl_l.m;
    dpl_l.c   = pl_l.c;
    dpl_l.len = len_l;
  end

  logic                  v_d;
  logic [2:0][QUO_W-1:0] quo_d;
  div_pl_t               pl_d;

  rssi_div #(.DW(LEN_W), .QW(QUO_W), .LN(3), .PW($bits(div_pl_t))) u_div (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .in_valid(v_l), .in_num(num_l), .in_den(len_l), .in_pl(dpl_l),
    .out_valid(v_d), .out_quo(quo_d), .out_pl(pl_d)
  );

  // ---------------- Stage E: signed direction, degenerate flag
  logic                  v_e_r, deg_e_r;
  logic [2:0][FLD_W-1:0] st_e_r, m_e_r;
  logic [2:0][DIR_W-1:0] dir_e_r;
  logic signed [C_W-1:0] c_e_r;
  logic [LEN_W-1:0]      len_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
    end else if (ce) begin
      v_e_r <= v_d;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        dir_e_r[i] <= pl_d.sgn[i] ? -DIR_W'(quo_d[i]) : DIR_W'(quo_d[i]);
      end
      st_e_r  <= pl_d.st;
      m_e_r   <= pl_d.m;
      c_e_r   <= pl_d.c;
      len_e_r <= pl_d.len;
      deg_e_r <= (pl_d.len == '0);
    end
  end

  // ---------------- Stage F: m_i * dir_i
  logic                   v_f_r, deg_f_r;
  logic signed [49:0]     pm_f_r [3];
  logic [2:0][FLD_W-1:0]  st_f_r;
  logic [2:0][DIR_W-1:0]  dir_f_r;
  logic signed [C_W-1:0]  c_f_r;
  logic [LEN_W-1:0]       len_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (ce) begin
      v_f_r <= v_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        pm_f_r[i] <= 50'($signed(m_e_r[i])) * 50'($signed(dir_e_r[i]));
      end
      st_f_r  <= st_e_r;
      dir_f_r <= dir_e_r;
      c_f_r   <= c_e_r;
      len_f_r <= len_e_r;
      deg_f_r <= deg_e_r;
    end
  end

  // ---------------- Stage G: b = sat(floor(sum / 2^16))
  logic                  v_g_r, deg_g_r;
  logic signed [FLD_W-1:0] b_g_r;
  logic [2:0][FLD_W-1:0] st_g_r;
  logic [2:0][DIR_W-1:0] dir_g_r;
  logic signed [C_W-1:0] c_g_r;
  logic [LEN_W-1:0]      len_g_r;
  logic signed [51:0]    bsum_nxt;

  assign bsum_nxt = 52'(pm_f_r[0]) + 52'(pm_f_r[1]) + 52'(pm_f_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g_r <= 1'b0;
    end else if (ce) begin
      v_g_r <= v_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      b_g_r   <= sat(64'(bsum_nxt >>> 16));
      st_g_r  <= st_f_r;
      dir_g_r <= dir_f_r;
      c_g_r   <= c_f_r;
      len_g_r <= len_f_r;
      deg_g_r <= deg_f_r;
    end
  end

  // ---------------- Stage H: b^2, outside-and-away test
  logic                    v_h_r, deg_h_r, away_h_r;
  logic [62:0]             bb_h_r;
  logic signed [FLD_W-1:0] b_h_r;
  logic [2:0][FLD_W-1:0]   st_h_r;
  logic [2:0][DIR_W-1:0]   dir_h_r;
  logic signed [C_W-1:0]   c_h_r;
  logic [LEN_W-1:0]        len_h_r;
  logic [63:0]             ba_nxt;

  assign ba_nxt = 64'(abs32(b_g_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_h_r <= 1'b0;
    end else if (ce) begin
      v_h_r <= v_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      bb_h_r   <= 63'(ba_nxt * ba_nxt);
      away_h_r <= (c_g_r > 0) && (b_g_r > 0);
      b_h_r    <= b_g_r;
      st_h_r   <= st_g_r;
      dir_h_r  <= dir_g_r;
      c_h_r    <= c_g_r;
      len_h_r  <= len_g_r;
      deg_h_r  <= deg_g_r;
    end
  end

  // ---------------- Stage I: discriminant
  logic               v_i_r;
  logic [SQ_XW-1:0]   dx_i_r;
  sq2_pl_t            pl_i_r;
  logic signed [49:0] discr_nxt;
  logic               miss_nxt;

  assign discr_nxt = 50'($signed({1'b0, bb_h_r[62:16]})) - 50'(c_h_r);
  assign miss_nxt  = away_h_r || (discr_nxt < 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_i_r <= 1'b0;
    end else if (ce) begin
      v_i_r <= v_h_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dx_i_r      <= miss_nxt ? '0 : {discr_nxt[47:0], 16'b0};
      pl_i_r.b    <= b_h_r;
      pl_i_r.st   <= st_h_r;
      pl_i_r.dir  <= dir_h_r;
      pl_i_r.len  <= len_h_r;
      pl_i_r.miss <= miss_nxt;
      pl_i_r.deg  <= deg_h_r;
    end
  end

  // ---------------- Discriminant root
  logic             v_q;
  logic [LEN_W-1:0] root_q;
  sq2_pl_t          pl_q;

  rssi_isqrt #(.XW(SQ_XW), .PW($bits(sq2_pl_t))) u_sqrt_disc (
    .clk(clk), .rst_n(rst_n), .ce(ce),
    .in_valid(v_i_r), .in_x(dx_i_r), .in_pl(pl_i_r),
    .out_valid(v_q), .out_root(root_q), .out_pl(pl_q)
  );

  // ---------------- Stage J: t = max(0, -b - root), hit test
  logic                  v_j_r, hit_j_r, zero_j_r, deg_j_r;
  logic [FLD_W-1:0]      t_j_r;
  logic [2:0][FLD_W-1:0] st_j_r;
  logic [2:0][DIR_W-1:0] dir_j_r;
  logic signed [33:0]    tw_nxt;
  logic [FLD_W-1:0]      t_nxt;

  assign tw_nxt = -34'($signed(pl_q.b)) - $signed({2'b00, root_q});
  assign t_nxt  = (tw_nxt < 0) ? '0 : tw_nxt[FLD_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_j_r <= 1'b0;
    end else if (ce) begin
      v_j_r <= v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t_j_r    <= t_nxt;
      zero_j_r <= pl_q.miss || pl_q.deg;
      deg_j_r  <= pl_q.deg;
      hit_j_r  <= !pl_q.miss && !pl_q.deg && (t_nxt <= pl_q.len);
      st_j_r   <= pl_q.st;
      dir_j_r  <= pl_q.dir;
    end
  end

  // ---------------- Stage K: dir_i * t
  logic                  hit_k_r, zero_k_r, deg_k_r;
  logic signed [50:0]    pd_k_r [3];
  logic [2:0][FLD_W-1:0] st_k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_k_r <= 1'b0;
    end else if (ce) begin
      v_k_r <= v_j_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < 3; i++) begin
        pd_k_r[i] <= 51'($signed(dir_j_r[i])) * 51'($signed({1'b0, t_j_r}));
      end
      st_k_r   <= st_j_r;
      hit_k_r  <= hit_j_r;
      zero_k_r <= zero_j_r;
      deg_k_r  <= deg_j_r;
    end
  end

  // ---------------- Output register: point = sat(start + floor(dir*t / 2^16))
  logic out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_can) begin
      out_valid_r <= v_k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_can) begin
      for (int i = 0; i < 3; i++) begin
        out_data_r[FLD_W*i +: FLD_W] <= zero_k_r ? '0 :
          sat(64'($signed(st_k_r[i])) + 64'(pd_k_r[i] >>> 16));
      end
      out_user_r[USR_HIT] <= hit_k_r;
      out_user_r[USR_DEG] <= deg_k_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

FILE: rtl/rssi_chk.sv
module rssi_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [rssi_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rssi_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [rssi_pkg::OUT_TUSER_W-1:0] out_tuser
);

  import rssi_pkg::*;

  // Stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  // Stalled result keeps its data
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("output payload changed while stalled");

  // A zero-length segment never hits
  a_deg_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USR_DEG] |-> !out_tuser[USR_HIT])
    else $error("degenerate result flagged as hit");

  // A zero-length segment reports the origin
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[USR_DEG] |-> out_tdata == '0)
    else $error("degenerate result with nonzero point");

  // With the output slot empty the input is always taken
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output slot is empty");

endmodule

bind ray_segment_sphere_intersect_top rssi_chk u_rssi_chk (.*);
